// ----- hw/rtl/vbhw_pkg.sv -----
// shared constants, types and saturating offset helpers for the block header walker
package vbhw_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS = 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_LEAD_SKIP   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_MARKED_TYPE = CFG_INDEX_BITS'(1);

    localparam logic [7:0] LEAD_SKIP_RESET   = 8'd8;
    localparam logic [7:0] MARKED_TYPE_RESET = 8'd3;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    typedef logic [OFFSET_BITS-1:0] offset_t;

    // result of shifting one byte into a vint accumulator
    typedef struct packed {
        logic [63:0] acc;
        logic [6:0]  shift;
        logic        ovf;
        logic        final_byte;
    } vint_res_t;

    function automatic offset_t sat_inc(offset_t a);
        offset_t r;
        if (a == OFF_MAX)
        begin
            r = OFF_MAX;
        end
        else
        begin
            r = a + offset_t'(1);
        end
        return r;
    endfunction

    function automatic offset_t sat_add(offset_t a, logic [63:0] b);
        logic [64:0] s;
        offset_t     r;
        s = 65'(a) + 65'(b);
        if (s > 65'(OFF_MAX))
        begin
            r = OFF_MAX;
        end
        else
        begin
            r = s[OFFSET_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] to_out32(offset_t a);
        logic [63:0] t;
        t = 64'(a);
        return t[31:0];
    endfunction

endpackage

// ----- hw/rtl/vbhw_byte_if.sv -----
// stream byte channel
interface vbhw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- hw/rtl/vbhw_rec_if.sv -----
// block record channel
interface vbhw_rec_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_start;
    logic [31:0] header_end;
    logic [63:0] block_type;
    logic [63:0] block_flags;
    logic [63:0] extra_size;
    logic [63:0] data_size;
    logic        is_marked;
    logic        overlong;
    logic        truncated;

    modport source (output valid, output block_start, output header_end, output block_type,
                    output block_flags, output extra_size, output data_size,
                    output is_marked, output overlong, output truncated, input ready);
    modport sink (input valid, input block_start, input header_end, input block_type,
                  input block_flags, input extra_size, input data_size,
                  input is_marked, input overlong, input truncated, output ready);
endinterface

// ----- hw/rtl/vbhw_cfg_if.sv -----
// register write channel
interface vbhw_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [vbhw_pkg::CFG_INDEX_BITS-1:0] index;
    logic [vbhw_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/vbhw_vint.sv -----
// one LEB128 byte step: shift-or into the accumulator and overflow check
module vbhw_vint
(
    input  logic [7:0]          data_byte,
    input  logic [63:0]         acc,
    input  logic [6:0]          shift,
    input  logic                ovf,
    output vbhw_pkg::vint_res_t res
);

    logic [6:0]  low;
    logic [70:0] wide;

    assign low = data_byte[6:0];

    always_comb
    begin
        wide = 71'(low) << shift[5:0];
        res.acc = acc;
        res.shift = shift;
        res.ovf = ovf;
        res.final_byte = ~data_byte[7];
        if (shift < 7'd64)
        begin
            res.acc = acc | wide[63:0];
            // bits pushed past bit 63 are lost
            if (wide[70:64] != 7'd0)
            begin
                res.ovf = 1'b1;
            end
            res.shift = shift + 7'd7;
        end
        else if (low != 7'd0)
        begin
            res.ovf = 1'b1;
        end
    end

endmodule

// ----- hw/rtl/vint_block_header_walker_unit.sv -----
// top level of the chained block header walker
//
// bytes carries the archive stream one byte per transaction, with last_byte
// on the final byte. After lead_skip signature bytes each block starts with
// four checksum bytes, then the vints header size, type, flags and, when the
// flags ask for them, extra size and data size. records delivers one
// transaction per complete block header, or a truncated one when the stream
// ends inside a header from its last checksum byte on. cfg writes lead_skip
// (index 0) and marked_type (index 1); it is always ready and should be
// used while the block is idle. Bytes pass the input register, then the
// parser state update that loads the record register. Throughput is one
// byte per cycle while records does not stall, set by the combinational
// vint shift-or and saturating offset add on the parser state. When records
// stalls with a record pending, the parser holds the next byte and bytes
// drops ready once the input register is full. Reset returns to the lead
// skip phase at offset 0, with registers at lead_skip 8 and marked_type 3.
module vint_block_header_walker_unit
(
    input logic        clk,
    input logic        rst_n,
    vbhw_byte_if.sink  bytes,
    vbhw_rec_if.source records,
    vbhw_cfg_if.sink   cfg
);

    typedef enum logic [2:0]
    {
        PH_LEAD,
        PH_SKIP,
        PH_CHECK,
        PH_HSIZE,
        PH_TYPE,
        PH_FLAGS,
        PH_EXTRA,
        PH_DATA
    } phase_t;

    typedef vbhw_pkg::offset_t offset_t;

    logic [7:0]  lead_skip_reg;
    logic [7:0]  marked_type_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    phase_t      phase_reg, phase_next;
    offset_t     position_reg, position_next;
    offset_t     skip_target_reg, skip_target_next;
    offset_t     start_offset_reg, start_offset_next;
    offset_t     end_offset_reg, end_offset_next;
    logic [1:0]  check_count_reg, check_count_next;
    logic [6:0]  shift_amount_reg, shift_amount_next;
    logic [63:0] accumulator_reg, accumulator_next;
    logic [63:0] type_value_reg, type_value_next;
    logic [63:0] flag_value_reg, flag_value_next;
    logic [63:0] extra_value_reg, extra_value_next;
    logic        overflow_seen_reg, overflow_seen_next;

    logic        out_valid_reg;
    logic [31:0] rec_start_reg;
    logic [31:0] rec_hend_reg;
    logic [63:0] rec_type_reg;
    logic [63:0] rec_flags_reg;
    logic [63:0] rec_extra_reg;
    logic [63:0] rec_data_reg;
    logic        rec_marked_reg;
    logic        rec_ovf_reg;
    logic        rec_trunc_reg;

    logic        fire;
    logic        emit;
    logic        emit_trunc;
    offset_t     emit_hend;
    logic [63:0] emit_type;
    logic [63:0] emit_flags;
    logic [63:0] emit_extra;
    logic [63:0] emit_data;
    logic        do_begin;
    logic        do_finish;
    logic [63:0] finish_data;
    offset_t     pos_inc;
    offset_t     hsize_sum;
    offset_t     skip_sum;

    vbhw_pkg::vint_res_t vt;

    vbhw_vint u_vint
    (
        .data_byte (in_byte_reg),
        .acc       (accumulator_reg),
        .shift     (shift_amount_reg),
        .ovf       (overflow_seen_reg),
        .res       (vt)
    );

    assign fire = in_valid_reg && (!out_valid_reg || records.ready);
    assign bytes.ready = !in_valid_reg || fire;
    assign cfg.ready = 1'b1;

    assign pos_inc = vbhw_pkg::sat_inc(position_reg);
    assign hsize_sum = vbhw_pkg::sat_add(pos_inc, vt.acc);

    // data size is only ever finished after the header size is known
    assign finish_data = (phase_reg == PH_DATA) ? vt.acc : 64'd0;
    assign skip_sum = vbhw_pkg::sat_add(end_offset_reg, finish_data);

    always_comb
    begin
        phase_next = phase_reg;
        position_next = position_reg;
        skip_target_next = skip_target_reg;
        start_offset_next = start_offset_reg;
        end_offset_next = end_offset_reg;
        check_count_next = check_count_reg;
        shift_amount_next = shift_amount_reg;
        accumulator_next = accumulator_reg;
        type_value_next = type_value_reg;
        flag_value_next = flag_value_reg;
        extra_value_next = extra_value_reg;
        overflow_seen_next = overflow_seen_reg;
        emit = 1'b0;
        emit_trunc = 1'b0;
        emit_hend = pos_inc;
        emit_type = 64'd0;
        emit_flags = 64'd0;
        emit_extra = 64'd0;
        emit_data = 64'd0;
        do_begin = 1'b0;
        do_finish = 1'b0;

        unique case (phase_reg)
            PH_SKIP:
            begin
                if (position_reg >= skip_target_reg)
                begin
                    do_begin = 1'b1;
                end
            end
            PH_CHECK:
            begin
                if (check_count_reg == 2'd3)
                begin
                    check_count_next = 2'd0;
                    accumulator_next = 64'd0;
                    shift_amount_next = 7'd0;
                    phase_next = PH_HSIZE;
                    if (in_last_reg)
                    begin
                        emit = 1'b1;
                        emit_trunc = 1'b1;
                    end
                end
                else
                begin
                    check_count_next = check_count_reg + 2'd1;
                end
            end
            PH_HSIZE, PH_TYPE, PH_FLAGS, PH_EXTRA, PH_DATA:
            begin
                accumulator_next = vt.acc;
                shift_amount_next = vt.shift;
                overflow_seen_next = vt.ovf;
                if (vt.final_byte)
                begin
                    accumulator_next = 64'd0;
                    shift_amount_next = 7'd0;
                    unique case (phase_reg)
                        PH_HSIZE:
                        begin
                            end_offset_next = hsize_sum;
                            phase_next = PH_TYPE;
                        end
                        PH_TYPE:
                        begin
                            type_value_next = vt.acc;
                            phase_next = PH_FLAGS;
                        end
                        PH_FLAGS:
                        begin
                            flag_value_next = vt.acc;
                            if (vt.acc[0])
                            begin
                                phase_next = PH_EXTRA;
                            end
                            else if (vt.acc[1])
                            begin
                                phase_next = PH_DATA;
                            end
                            else
                            begin
                                do_finish = 1'b1;
                            end
                        end
                        PH_EXTRA:
                        begin
                            extra_value_next = vt.acc;
                            if (flag_value_reg[1])
                            begin
                                phase_next = PH_DATA;
                            end
                            else
                            begin
                                do_finish = 1'b1;
                            end
                        end
                        default:
                        begin
                            do_finish = 1'b1;
                        end
                    endcase
                end

                if (do_finish)
                begin
                    emit = 1'b1;
                    emit_hend = end_offset_reg;
                    emit_type = type_value_next;
                    emit_flags = flag_value_next;
                    emit_extra = extra_value_next;
                    emit_data = finish_data;
                    skip_target_next = skip_sum;
                    phase_next = PH_SKIP;
                end
                else if (in_last_reg)
                begin
                    // stream ends inside the header: report what has been read
                    emit = 1'b1;
                    emit_trunc = 1'b1;
                    emit_hend = (phase_next == PH_HSIZE) ? hsize_sum : end_offset_next;
                    emit_type = (phase_next == PH_TYPE) ? accumulator_next : type_value_next;
                    emit_flags = (phase_next == PH_FLAGS) ? accumulator_next : flag_value_next;
                    emit_extra = (phase_next == PH_EXTRA) ? accumulator_next : extra_value_next;
                    emit_data = (phase_next == PH_DATA) ? accumulator_next : 64'd0;
                end
            end
            default:
            begin
                phase_next = PH_LEAD;
                if (position_reg >= offset_t'(lead_skip_reg))
                begin
                    do_begin = 1'b1;
                end
            end
        endcase

        if (do_begin)
        begin
            start_offset_next = position_reg;
            check_count_next = 2'd1;
            end_offset_next = '0;
            type_value_next = 64'd0;
            flag_value_next = 64'd0;
            extra_value_next = 64'd0;
            accumulator_next = 64'd0;
            shift_amount_next = 7'd0;
            overflow_seen_next = 1'b0;
            phase_next = PH_CHECK;
        end

        if (in_last_reg)
        begin
            position_next = '0;
            phase_next = PH_LEAD;
        end
        else
        begin
            position_next = pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_skip_reg <= vbhw_pkg::LEAD_SKIP_RESET;
            marked_type_reg <= vbhw_pkg::MARKED_TYPE_RESET;
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg <= PH_LEAD;
            position_reg <= '0;
            skip_target_reg <= '0;
            start_offset_reg <= '0;
            end_offset_reg <= '0;
            check_count_reg <= 2'd0;
            shift_amount_reg <= 7'd0;
            accumulator_reg <= 64'd0;
            type_value_reg <= 64'd0;
            flag_value_reg <= 64'd0;
            extra_value_reg <= 64'd0;
            overflow_seen_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                if (cfg.index == vbhw_pkg::REG_LEAD_SKIP)
                begin
                    lead_skip_reg <= cfg.data;
                end
                else if (cfg.index == vbhw_pkg::REG_MARKED_TYPE)
                begin
                    marked_type_reg <= cfg.data;
                end
            end

            if (bytes.valid && bytes.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                phase_reg <= phase_next;
                position_reg <= position_next;
                skip_target_reg <= skip_target_next;
                start_offset_reg <= start_offset_next;
                end_offset_reg <= end_offset_next;
                check_count_reg <= check_count_next;
                shift_amount_reg <= shift_amount_next;
                accumulator_reg <= accumulator_next;
                type_value_reg <= type_value_next;
                flag_value_reg <= flag_value_next;
                extra_value_reg <= extra_value_next;
                overflow_seen_reg <= overflow_seen_next;
            end

            if (fire && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (records.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            in_byte_reg <= bytes.data_byte;
            in_last_reg <= bytes.last_byte;
        end
        if (fire && emit)
        begin
            rec_start_reg <= vbhw_pkg::to_out32(start_offset_next);
            rec_hend_reg <= vbhw_pkg::to_out32(emit_hend);
            rec_type_reg <= emit_type;
            rec_flags_reg <= emit_flags;
            rec_extra_reg <= emit_extra;
            rec_data_reg <= emit_data;
            rec_marked_reg <= (emit_type == 64'(marked_type_reg));
            rec_ovf_reg <= overflow_seen_next;
            rec_trunc_reg <= emit_trunc;
        end
    end

    assign records.valid = out_valid_reg;
    assign records.block_start = rec_start_reg;
    assign records.header_end = rec_hend_reg;
    assign records.block_type = rec_type_reg;
    assign records.block_flags = rec_flags_reg;
    assign records.extra_size = rec_extra_reg;
    assign records.data_size = rec_data_reg;
    assign records.is_marked = rec_marked_reg;
    assign records.overlong = rec_ovf_reg;
    assign records.truncated = rec_trunc_reg;

endmodule
